// ===== hw/rtl/running_average_filter_assert.svh =====
// Assertion macros for the running average filter.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef RUNNING_AVERAGE_FILTER_ASSERT_SVH
`define RUNNING_AVERAGE_FILTER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define RAF_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("running_average_filter: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define RAF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running_average_filter: implication violated");

// Consequent holds in the cycle after the antecedent.
`define RAF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running_average_filter: sequence violated");

`endif

// ===== hw/rtl/raf_pkg.sv =====
// Shared types and fixed constants of the running average filter.
// Depends on nothing.
package raf_pkg;

    localparam int AVG_BITS         = 16;
    localparam int LEN_BITS         = 6;
    localparam int WINDOW_LEN_RESET = 20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_START,
        S_DIV,
        S_LOAD
    } raf_state_t;

endpackage

// ===== hw/rtl/raf_sample_ram.sv =====
// Sample store of the running average filter: one write port, one read port.
// Read data is registered. Depends on nothing.
module raf_sample_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/raf_serial_div.sv =====
// Restoring divider of the running average filter, one quotient bit a cycle.
// Depends on nothing.
module raf_serial_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = diff[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== hw/rtl/running_average_filter.sv =====
// Running average filter top level: sequencer, window bookkeeping, output word.
// Depends on raf_pkg, raf_sample_ram, raf_serial_div and the assertion header.
//
// Use of the block:
//   Input channel in_valid / in_ready / sample carries one sample word; the
//   output channel out_valid / out_ready / average returns one word per sample,
//   the truncated mean of the samples now in the window.
//   window_len_we with window_len sets the window length (zero counts as one,
//   values above MAX_WINDOW as MAX_WINDOW) and clears the window; write it
//   only while no sample is in flight.
//   After acceptance the sequencer steps through update, divider start,
//   division (one quotient bit a cycle) and load into the output register.
//   A new sample is taken only after the last one has reached the output
//   register; in_ready is high only while the sequencer is idle.
//   The result sits in an output register, so a new sample is taken while an
//   earlier result still waits; if the receiver stalls, the next result
//   holds in the divider until the output register empties.
//   Reset clears the window (sum, position, fill count) and sets the window
//   length to 20, or MAX_WINDOW if smaller. Store entries are not cleared:
//   the fill count marks which entries hold live samples.
`include "running_average_filter_assert.svh"

module running_average_filter
    import raf_pkg::*;
#(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   window_len_we,
    input  logic [LEN_BITS-1:0]    window_len,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [AVG_BITS-1:0]    average
);

    // widths of the window bookkeeping
    localparam int PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int QW    = (SUM_W > AVG_BITS) ? SUM_W : AVG_BITS;
    localparam int IW    = ((PW > CW) ? PW : CW) + 1;
    localparam int LEN_RESET =
        (WINDOW_LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_LEN_RESET;

    raf_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          len_reg, len_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [AVG_BITS-1:0]    avg_reg, avg_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   accept;
    logic                   update;
    logic                   div_start;
    logic                   div_done;
    logic                   load;
    logic                   out_free;
    logic [CW-1:0]          len_clamp;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [IW-1:0]          pos_inc;
    logic [IW-1:0]          pos_ext;
    logic [IW-1:0]          len_ext;
    logic [SUM_W-1:0]       quotient;
    logic [QW-1:0]          quot_ext;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // saturate the written window length into 1 .. MAX_WINDOW
    always_comb
    begin
        if (window_len == '0)
        begin
            len_clamp = CW'(1);
        end
        else if (int'(window_len) > MAX_WINDOW)
        begin
            len_clamp = CW'(MAX_WINDOW);
        end
        else
        begin
            len_clamp = CW'(window_len);
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_UPDATE;
            S_UPDATE: state_next = S_START;
            S_START:  state_next = S_DIV;
            S_DIV:    if (div_done) state_next = S_LOAD;
            S_LOAD:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        update    = 1'b0;
        div_start = 1'b0;
        load      = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready  = 1'b1;
            S_UPDATE: update    = 1'b1;
            S_START:  div_start = 1'b1;
            S_DIV:    ;
            S_LOAD:   load      = out_free;
            default:  ;
        endcase
    end

    // ---------------------------------------------------------- window update
    // Until the window has filled, the entry at the write position has not
    // been written since the last clear, so it counts as zero.
    assign old_sample = (fill_reg == len_reg) ? rd_data : '0;

    assign pos_ext = IW'(pos_reg);
    assign len_ext = IW'(len_reg);
    assign pos_inc = pos_ext + IW'(1);

    always_comb
    begin
        sample_next = sample_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        if (accept)
        begin
            sample_next = sample;
        end
        if (window_len_we)
        begin
            // drop the whole window on any length write
            len_next  = len_clamp;
            pos_next  = '0;
            fill_next = '0;
            sum_next  = '0;
        end
        else if (update)
        begin
            sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
            if (pos_inc >= len_ext)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc[PW-1:0];
            end
            if (fill_reg < len_reg)
            begin
                fill_next = fill_reg + CW'(1);
            end
        end
    end

    // ----------------------------------------------------------- output word
    assign quot_ext = QW'(quotient);

    always_comb
    begin
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            avg_next       = quot_ext[AVG_BITS-1:0];
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            fill_reg      <= '0;
            len_reg       <= CW'(LEN_RESET);
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        avg_reg    <= avg_next;
    end

    assign out_valid = out_valid_reg;
    assign average   = avg_reg;

    // ------------------------------------------------------------ sub-blocks
    // Read the oldest entry as the sample is taken; overwrite it in the cycle after, in the update step.
    raf_sample_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS),
        .AW    (PW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (update),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    // Divide the updated sum by the updated fill count, which is at least one.
    raf_serial_div #(
        .NUM_W (SUM_W),
        .DEN_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // ------------------------------------------------------------ assertions
    `RAF_ASSERT_ALWAYS(a_fill_within_len, fill_reg <= len_reg)
    `RAF_ASSERT_ALWAYS(a_pos_within_len, pos_ext < len_ext)
    `RAF_ASSERT_IMPL(a_done_only_in_div, div_done, state_reg == S_DIV)
    `RAF_ASSERT_NEXT(a_accept_then_update, accept, state_reg == S_UPDATE)

endmodule

// ===== dv/running_average_filter_tb.sv =====
// Self-checking testbench for running_average_filter: sliding-window mean of sample words.
// Depends on raf_pkg and the running_average_filter RTL; needs nothing else.
`timescale 1ns / 100ps

module running_average_filter_tb;
    import raf_pkg::*;

    localparam int MAX_WIN     = 32;
    localparam int SAMPLE_W    = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_TAIL  = 60;   // quiet tail after the final drain, longer than the block's latency

    // Mean predictor and store of awaited averages, in the order they must come out.
    class avg_scoreboard;
        logic [SAMPLE_W-1:0] ring [MAX_WIN];
        logic [4:0]          slot;
        logic [5:0]          filled;
        logic [5:0]          win;
        logic [20:0]         sum;
        logic [AVG_BITS-1:0] awaited_q [$];
        int unsigned         mismatches;
        int unsigned         checked;
        int unsigned         noted;

        function new();
            mismatches = 0;
            checked    = 0;
            noted      = 0;
            set_window(LEN_BITS'(WINDOW_LEN_RESET));
        endfunction

        // Saturate the length into 1..MAX_WIN and empty the window.
        function void set_window(logic [LEN_BITS-1:0] v);
            if (v == 0)
                win = 6'd1;
            else if (v > MAX_WIN)
                win = 6'(MAX_WIN);
            else
                win = v;
            foreach (ring[i])
                ring[i] = '0;
            slot   = '0;
            filled = '0;
            sum    = '0;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            int unsigned pos;
            pos = slot;
            if (pos >= win)
                pos = 0;
            sum       = sum - 21'(ring[pos]) + 21'(s);
            ring[pos] = s;
            pos++;
            if (pos >= win)
                pos = 0;
            slot = 5'(pos);
            if (filled < win)
                filled++;
            awaited_q.push_back(AVG_BITS'(sum / 21'(filled)));
            noted++;
        endfunction

        function int unsigned pending();
            return awaited_q.size();
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH %s", $time, what);
            mismatches++;
        endtask

        task check_average(logic [AVG_BITS-1:0] got);
            logic [AVG_BITS-1:0] want;
            if (awaited_q.size() == 0)
            begin
                report($sformatf("unexpected average word %0d", got));
            end
            else
            begin
                want = awaited_q.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("average: got %0d, want %0d (word %0d)",
                                     got, want, checked));
            end
        endtask
    endclass

    // Block inputs, all known from time zero.
    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   window_len_we = 1'b0;
    logic [LEN_BITS-1:0]    window_len    = '0;
    logic                   in_valid      = 1'b0;
    logic [SAMPLE_W-1:0]    sample        = '0;
    logic                   out_ready     = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [AVG_BITS-1:0]    average;

    avg_scoreboard sb = new();

    int unsigned cycles       = 0;
    int unsigned burst_left   = 0;
    int unsigned streak_left  = 0;
    logic [SAMPLE_W-1:0] streak_val = '0;
    int unsigned settings_run = 0;
    int unsigned drains       = 0;

    running_average_filter #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_BITS (SAMPLE_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_len_we (window_len_we),
        .window_len    (window_len),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average       (average)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: stop a hung run rather than let it spin.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles, %0d averages still awaited",
                     cycles, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver. Check every accepted average word, then pick next cycle's ready.
    // The stall mode is redrawn periodically from the cycle counter: always ready, coin toss, mostly
    // ready with occasional long stalls, or mostly stalled.
    int unsigned rx_mode  = 0;
    int unsigned rx_stall = 0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_average(average);

        if (cycles % 128 == 0)
            rx_mode = $urandom_range(0, 3);

        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2:
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        rx_stall = $urandom_range(1, 60);
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                    end
                end
                default: out_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Present one sample word and hold it until the block takes it.
    // Call only just after a rising edge; valid is left high for the caller.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_sample(s);
    endtask

    // Sender pacing: bursts of random length, then a gap that may be zero,
    // short or longer than the block's latency.
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(4, 30);
                default: gap = $urandom_range(0, 8);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Drop valid and hold off until every awaited average has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        drains++;
    endtask

    // Write the window length; only ever called with the block drained.
    task automatic set_window_len(input logic [LEN_BITS-1:0] v);
        window_len_we <= 1'b1;
        window_len    <= v;
        @(posedge clk);
        window_len_we <= 1'b0;
        sb.set_window(v);
        settings_run++;
    endtask

    // Mostly uniform words, with streaks of all-zero or all-one words so that
    // the window sum reaches both ends.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        if (streak_left == 0 && $urandom_range(0, 14) == 0)
        begin
            streak_left = $urandom_range(1, 40);
            streak_val  = $urandom_range(0, 1) ? '1 : '0;
        end
        if (streak_left > 0)
        begin
            streak_left--;
            return streak_val;
        end
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(0, 15));
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    logic [LEN_BITS-1:0] fixed_lens [8] = '{6'd32, 6'd1, 6'd63, 6'd0,
                                            6'd33, 6'd20, 6'd2, 6'd31};

    initial
    begin
        int unsigned n_items;
        logic [LEN_BITS-1:0] len_val;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and alternating bit patterns at the reset length.
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hAAAA);
        send_sample(16'h5555);

        // A zero length behaves as a one-word window: each average is its sample.
        drain();
        set_window_len(6'd0);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h3039);

        // Rewrite the same length: it must still clear the window.
        drain();
        set_window_len(6'd0);
        send_sample(16'h1234);

        // Lengths above the maximum saturate; three all-ones words then enter
        // the cleared window.
        drain();
        set_window_len(6'd63);
        repeat (3) send_sample(16'hFFFF);

        // Random phases, one window length each, drained before every write.
        for (int ph = 0; ph < 12; ph++)
        begin
            drain();
            len_val = (ph < 8) ? fixed_lens[ph] : LEN_BITS'($urandom_range(0, 63));
            set_window_len(len_val);
            n_items = $urandom_range(70, 120);
            for (int k = 0; k < n_items; k++)
            begin
                send_sample(pick_sample());
                // Now and then let the block go fully idle without a rewrite.
                if ($urandom_range(0, 149) == 0)
                    drain();
                else
                    pace();
            end
        end

        // Wait out the awaited averages, then a quiet tail to catch strays.
        drain();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("%0d sample words sent over %0d window-length writes, %0d full drains;",
                 sb.noted, settings_run, drains);
        $display("%0d averages checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
